/* rtl/key_to_wire_id_mapper_unit_defines.svh */
// Assertion macros shared by the key to wire id mapper RTL
`ifndef KEY_TO_WIRE_ID_MAPPER_UNIT_DEFINES_SVH
`define KEY_TO_WIRE_ID_MAPPER_UNIT_DEFINES_SVH

// plain property, checked on every edge out of reset
`define KWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define KWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/kwm_pkg.sv */
// Types and constants of the key to wire id mapper
package kwm_pkg;

  localparam int unsigned KeyWordW  = 64;
  localparam int unsigned LenW      = 6;
  localparam int unsigned ReqIdW    = 16;
  localparam int unsigned IdW       = 8;
  localparam int unsigned IdCount   = 256;
  localparam logic [IdW-1:0] IdMax  = 8'd255;
  localparam int unsigned IdGroupW  = 16;
  localparam int unsigned IdGroups  = IdCount / IdGroupW;
  localparam int unsigned GroupAw   = 4;
  localparam int unsigned GroupBitAw = 4;
  // id 0 stays reserved
  localparam logic [IdCount-1:0] IdResetMap = {{(IdCount-1){1'b0}}, 1'b1};

  typedef enum logic {
    FUNC_MAP   = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    func_e               func;
    logic [KeyWordW-1:0] key_word0;
    logic [KeyWordW-1:0] key_word1;
    logic [KeyWordW-1:0] key_word2;
    logic [KeyWordW-1:0] key_word3;
    logic [LenW-1:0]     key_len;
    logic [ReqIdW-1:0]   requested_id;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0] wire_id;
    logic           failed;
    logic           was_hit;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

/* rtl/key_to_wire_id_mapper_unit.sv */
// Map item: after accept, a scan of the slots and id groups, then commit, then the result strobe.
// A new word is taken the cycle after the strobe; no new item is accepted while one is in flight.
// Clear item: no scan; commit, then the result strobe.
// The map scan walks the single-port slot store one slot per cycle.
// Reset (async, active low) empties both maps and idles; results cannot be stalled.
module key_to_wire_id_mapper_unit #(
  parameter int unsigned MAP_ENTRIES = 64,
  parameter int unsigned KEY_BYTES   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  kwm_pkg::req_t req_i,
  output logic          done_o,
  output kwm_pkg::rsp_t rsp_o
);
  import kwm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  kwm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (req_i.func),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  kwm_dpath #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

/* rtl/kwm_dpath.sv */
// Datapath: key store, slot and id scan, id allocation and result register
`include "key_to_wire_id_mapper_unit_defines.svh"

module kwm_dpath #(
  parameter int unsigned MAP_ENTRIES = 64,
  parameter int unsigned KEY_BYTES   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kwm_pkg::req_t req_i,
  input  kwm_pkg::ctl_t ctl_i,
  output kwm_pkg::sts_t sts_o,
  output kwm_pkg::rsp_t rsp_o
);
  import kwm_pkg::*;

  localparam int unsigned KeyBits  = KEY_BYTES * 8;
  localparam int unsigned SlotAw   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int unsigned ScanLast = (MAP_ENTRIES > IdGroups - 1) ? MAP_ENTRIES : IdGroups - 1;
  localparam int unsigned CntW     = $clog2(ScanLast + 1);
  localparam int unsigned RowW     = IdW + LenW + KeyBits;

  // item registers
  func_e              func_q;
  logic [KeyBits-1:0] key_q;
  logic [LenW-1:0]    len_q;
  logic [ReqIdW-1:0]  req_q;

  logic [LenW-1:0]    len_sat;
  logic [4*KeyWordW-1:0] key_all;
  logic [KeyBits-1:0] key_msk;

  assign len_sat = (req_i.key_len > LenW'(KEY_BYTES)) ? LenW'(KEY_BYTES) : req_i.key_len;
  assign key_all = {req_i.key_word3, req_i.key_word2, req_i.key_word1, req_i.key_word0};

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_msk[b*8 +: 8] = (LenW'(b) < len_sat) ? key_all[b*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      func_q <= req_i.func;
      key_q  <= key_msk;
      len_q  <= len_sat;
      req_q  <= req_i.requested_id;
    end
  end

  // scan counter walks slots and id groups together
  logic [CntW-1:0]   cnt_q;
  logic              in_slots;
  logic              grp_in;
  logic [SlotAw-1:0] rd_idx;

  assign in_slots = cnt_q < CntW'(MAP_ENTRIES);
  assign grp_in   = cnt_q < CntW'(IdGroups);
  assign rd_idx   = cnt_q[SlotAw-1:0];
  assign sts_o.scan_last = cnt_q == CntW'(ScanLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.load) begin
      cnt_q <= '0;
    end else if (ctl_i.scan) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // slot store: {id, len, key} per row
  logic [RowW-1:0]   slot_mem [MAP_ENTRIES];
  logic [RowW-1:0]   rdata_q;
  logic [RowW-1:0]   wrow;
  logic              mem_we;
  logic [SlotAw-1:0] slot_idx_q;
  logic [IdW-1:0]    alloc_id;

  assign wrow = {alloc_id, len_q, key_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[slot_idx_q] <= wrow;
    end
    if (ctl_i.scan) begin
      rdata_q <= slot_mem[rd_idx];
    end
  end

  logic [IdW-1:0]     rd_id;
  logic [LenW-1:0]    rd_len;
  logic [KeyBits-1:0] rd_key;

  assign rd_id  = rdata_q[RowW-1 -: IdW];
  assign rd_len = rdata_q[KeyBits +: LenW];
  assign rd_key = rdata_q[KeyBits-1:0];

  logic [MAP_ENTRIES-1:0] slot_valid_q;
  logic [IdCount-1:0]     id_used_q;

  // compare stage sees each read address in the cycle after it is issued
  logic              cmp_vld_q;
  logic [SlotAw-1:0] cmp_idx_q;
  logic              hit_now;
  logic              hit_q;
  logic [IdW-1:0]    hit_id_q;
  logic              slot_fnd_q;

  assign hit_now = cmp_vld_q && slot_valid_q[cmp_idx_q] && (rd_len == len_q) && (rd_key == key_q);

  // lowest free id inside the current group of 16
  logic [IdGroupW-1:0]   grp_bits;
  logic                  grp_free;
  logic [GroupBitAw-1:0] grp_pos;
  logic                  free_q;
  logic [IdW-1:0]        free_id_q;

  assign grp_bits = id_used_q[{cnt_q[GroupAw-1:0], {GroupBitAw{1'b0}}} +: IdGroupW];

  always_comb begin
    grp_free = 1'b0;
    grp_pos  = '0;
    for (int k = IdGroupW - 1; k >= 0; k--) begin
      if (!grp_bits[k]) begin
        grp_free = 1'b1;
        grp_pos  = GroupBitAw'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      slot_fnd_q <= 1'b0;
      free_q     <= 1'b0;
    end else if (ctl_i.load) begin
      cmp_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      slot_fnd_q <= 1'b0;
      free_q     <= 1'b0;
    end else if (ctl_i.scan) begin
      cmp_vld_q <= in_slots && (len_q != '0);
      if (hit_now && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (in_slots && !slot_valid_q[rd_idx] && !slot_fnd_q) begin
        slot_fnd_q <= 1'b1;
      end
      if (grp_in && grp_free && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan) begin
      cmp_idx_q <= rd_idx;
      if (hit_now && !hit_q) begin
        hit_id_q <= rd_id;
      end
      if (in_slots && !slot_valid_q[rd_idx] && !slot_fnd_q) begin
        slot_idx_q <= rd_idx;
      end
      if (grp_in && grp_free && !free_q) begin
        free_id_q <= {cnt_q[GroupAw-1:0], grp_pos};
      end
    end
  end

  // allocation and result
  logic           req_ok;
  logic           set_id;
  rsp_t           rsp_d;
  rsp_t           rsp_q;

  assign req_ok = (req_q[ReqIdW-1:IdW] == '0) && (req_q[IdW-1:0] != '0) &&
                  (req_q[IdW-1:0] <= IdMax) && !id_used_q[req_q[IdW-1:0]];
  assign alloc_id = req_ok ? req_q[IdW-1:0] : (free_q ? free_id_q : '0);

  always_comb begin
    rsp_d  = '0;
    set_id = 1'b0;
    mem_we = 1'b0;
    if (func_q == FUNC_MAP) begin
      if (hit_q) begin
        rsp_d.wire_id = hit_id_q;
        rsp_d.was_hit = 1'b1;
      end else if (alloc_id == '0) begin
        rsp_d.failed = 1'b1;
      end else begin
        rsp_d.wire_id = alloc_id;
        set_id = ctl_i.commit;
        // map full: id handed out, key not kept
        mem_we = ctl_i.commit && (len_q != '0) && slot_fnd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_used_q    <= IdResetMap;
      slot_valid_q <= '0;
    end else if (ctl_i.commit && (func_q == FUNC_CLEAR)) begin
      id_used_q    <= IdResetMap;
      slot_valid_q <= '0;
    end else begin
      if (set_id) begin
        id_used_q[alloc_id] <= 1'b1;
      end
      if (mem_we) begin
        slot_valid_q[slot_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  `KWM_ASSERT(a_id0_reserved, id_used_q[0], "id 0 lost its reserved mark")
  `KWM_ASSERT_NXT(a_alloc_marks_used, set_id, id_used_q[$past(alloc_id)], "allocated id not marked used")
  `KWM_ASSERT_IMP(a_hit_needs_key, hit_q, (len_q != '0) && (func_q == FUNC_MAP), "hit without a key")

endmodule

/* rtl/kwm_ctrl.sv */
// Controller: sequences load, scan, commit and the result strobe
`include "key_to_wire_id_mapper_unit_defines.svh"

module kwm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  kwm_pkg::func_e func_i,
  input  kwm_pkg::sts_t  sts_i,
  output kwm_pkg::ctl_t  ctl_o,
  output logic           busy_o,
  output logic           done_o
);
  import kwm_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.load = 1'b1;
          // clear needs no scan
          state_d = (func_i == FUNC_CLEAR) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `KWM_ASSERT_NXT(a_done_then_idle, done_o, !busy_o, "not idle after result strobe")
  `KWM_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word did not raise busy")
  `KWM_ASSERT(a_one_cmd, $onehot0({ctl_o.load, ctl_o.scan, ctl_o.commit}), "overlapping commands")

endmodule
